>>> design/qom_pkg.sv
package qom_pkg;

  // Operation carried by an event.
  typedef enum logic {
    OP_ENTER = 1'b0,
    OP_LEAVE = 1'b1
  } op_t;

  // Status reported with every result.
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY_REMOVE = 2'd1,
    ST_FULL_INSERT  = 2'd2,
    ST_TIME_BACK    = 2'd3
  } status_t;

  // Fixed field widths of the ports.
  localparam int SEL_W  = 2;
  localparam int TS_W   = 32;
  localparam int OCC_W  = 16;
  localparam int SUM_W  = 64;
  localparam int IDLE_W = 32;

  // Depths of the queue between front and back, and of the result queue.
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

  // Saturation limits.
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // Classified event handed from the front to the back.
  typedef struct packed {
    op_t              op;
    logic             hit;
    logic [SEL_W-1:0] qsel;
    logic [TS_W-1:0]  ts;
  } event_t;

  // One finished result.
  typedef struct packed {
    logic [OCC_W-1:0]  occupancy;
    logic [OCC_W-1:0]  peak;
    logic [SUM_W-1:0]  weighted_sum;
    logic [IDLE_W-1:0] idle_time;
    status_t           status;
  } result_t;

endpackage

>>> design/qom_front.sv
module qom_front #(
  parameter int NUM_QUEUES = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_op,
  input  logic [qom_pkg::SEL_W-1:0]   in_queue_sel,
  input  logic [qom_pkg::TS_W-1:0]    in_timestamp,
  output logic                        ev_valid,
  output qom_pkg::event_t             ev,
  input  logic                        ev_take
);
  import qom_pkg::*;

  localparam int MPW = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
  localparam int MCW = $clog2(MID_DEPTH + 1);

  event_t           mem_r [MID_DEPTH];
  logic [MPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [MPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [MCW-1:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;
  event_t           ev_in;

  // Classify the incoming transaction: mark whether the queue exists.
  always_comb begin
    ev_in.op   = op_t'(in_op);
    ev_in.hit  = int'(in_queue_sel) < NUM_QUEUES;
    ev_in.qsel = in_queue_sel;
    ev_in.ts   = in_timestamp;
  end

  assign in_full  = (cnt_r == MCW'(MID_DEPTH));
  assign do_push  = in_push && !in_full;
  assign ev_valid = (cnt_r != '0);
  assign do_pop   = ev_take && ev_valid;
  assign ev       = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == MPW'(MID_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == MPW'(MID_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Event storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= ev_in;
    end
  end

endmodule

>>> design/qom_back.sv
module qom_back #(
  parameter int NUM_QUEUES  = 3,
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ev_valid,
  input  qom_pkg::event_t                 ev,
  output logic                            ev_take,
  input  logic [qom_pkg::OUT_LVL_W-1:0]   out_level,
  output logic                            res_valid,
  output qom_pkg::result_t                res
);
  import qom_pkg::*;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW = COUNT_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int PW = CW + TW;
  localparam int MW = (PW > SUM_W) ? PW : SUM_W;
  localparam int IW = ((TW > IDLE_W) ? TW : IDLE_W) + 1;

  // Per-queue state.
  logic [CW-1:0]     count_r  [NUM_QUEUES];
  logic [CW-1:0]     peak_r   [NUM_QUEUES];
  logic [TW-1:0]     last_r   [NUM_QUEUES];
  logic [IDLE_W-1:0] idle_r   [NUM_QUEUES];
  logic [SUM_W-1:0]  wsum_r   [NUM_QUEUES];

  // Stage B registers.
  logic              b_valid_r;
  logic              b_hit_r;
  logic [QW-1:0]     b_idx_r;
  logic [CW-1:0]     b_cnt_r;
  logic [TW-1:0]     b_ivl_r;
  logic              b_empty_r;
  logic [OCC_W-1:0]  b_occ_r;
  logic [OCC_W-1:0]  b_peak_r;
  status_t           b_stat_r;

  // Stage C registers.
  logic              c_valid_r;
  logic              c_hit_r;
  logic [QW-1:0]     c_idx_r;
  logic [SUM_W-1:0]  c_prod_r;
  logic [OCC_W-1:0]  c_occ_r;
  logic [OCC_W-1:0]  c_peak_r;
  logic [IDLE_W-1:0] c_idle_r;
  status_t           c_stat_r;

  // Stage A signals.
  logic [QW-1:0]     a_idx;
  logic [TW-1:0]     a_now;
  logic [TW-1:0]     a_last;
  logic [CW-1:0]     a_cnt;
  logic [CW-1:0]     a_pk;
  logic              a_back;
  logic [TW-1:0]     a_ivl;
  logic [CW-1:0]     a_cnt_nxt;
  logic [CW-1:0]     a_pk_nxt;
  status_t           a_stat;
  logic              a_upd;

  // Stage B signals.
  logic [IDLE_W-1:0] b_idle_old;
  logic [IW-1:0]     b_idle_sum;
  logic [IDLE_W-1:0] b_idle_nxt;
  logic [PW-1:0]     b_prod_full;
  logic [MW-1:0]     b_prod_ext;
  logic [SUM_W-1:0]  b_prod_sat;

  // Stage C signals.
  logic [SUM_W:0]    c_sum;
  logic [SUM_W-1:0]  c_wsum_nxt;

  // Issue only while the result queue has room for everything in flight.
  assign ev_take = ev_valid &&
                   ((int'(out_level) + int'(b_valid_r) + int'(c_valid_r)) < OUT_DEPTH);
  assign a_upd   = ev_take && ev.hit;

  // Stage A: interval, occupancy and peak for the selected queue.
  always_comb begin
    a_idx     = QW'(ev.qsel);
    a_now     = TW'(ev.ts);
    a_last    = last_r[a_idx];
    a_cnt     = count_r[a_idx];
    a_pk      = peak_r[a_idx];
    a_back    = a_now < a_last;
    a_ivl     = a_back ? '0 : a_now - a_last;
    a_stat    = a_back ? ST_TIME_BACK : ST_OK;
    a_cnt_nxt = a_cnt;
    a_pk_nxt  = a_pk;
    if (ev.op == OP_ENTER) begin
      if (a_cnt == {CW{1'b1}}) begin
        if (!a_back) begin
          a_stat = ST_FULL_INSERT;
        end
      end else begin
        a_cnt_nxt = a_cnt + 1'b1;
      end
      if (a_cnt_nxt > a_pk) begin
        a_pk_nxt = a_cnt_nxt;
      end
    end else begin
      if (a_cnt == '0) begin
        if (!a_back) begin
          a_stat = ST_EMPTY_REMOVE;
        end
      end else begin
        a_cnt_nxt = a_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        count_r[i] <= '0;
        peak_r[i]  <= '0;
        last_r[i]  <= '0;
      end
    end else if (a_upd) begin
      count_r[a_idx] <= a_cnt_nxt;
      peak_r[a_idx]  <= a_pk_nxt;
      if (!a_back) begin
        last_r[a_idx] <= a_now;
      end
    end
  end

  // Stage B control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= ev_take;
    end
  end

  // Stage B payload.
  always_ff @(posedge clk) begin
    if (ev_take) begin
      b_hit_r   <= ev.hit;
      b_idx_r   <= a_idx;
      b_cnt_r   <= a_cnt;
      b_ivl_r   <= a_ivl;
      b_empty_r <= (a_cnt == '0);
      b_occ_r   <= OCC_W'(a_cnt_nxt);
      b_peak_r  <= OCC_W'(a_pk_nxt);
      b_stat_r  <= a_stat;
    end
  end

  // Stage B: idle accumulation and the occupancy-interval product.
  always_comb begin
    b_idle_old  = idle_r[b_idx_r];
    b_idle_sum  = IW'(b_idle_old) + IW'(b_ivl_r);
    b_idle_nxt  = (b_idle_sum > IW'(IDLE_MAX)) ? IDLE_MAX : b_idle_sum[IDLE_W-1:0];
    b_prod_full = PW'(b_cnt_r) * PW'(b_ivl_r);
    b_prod_ext  = MW'(b_prod_full);
    b_prod_sat  = (b_prod_ext > MW'(SUM_MAX)) ? SUM_MAX : b_prod_ext[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        idle_r[i] <= '0;
      end
    end else if (b_valid_r && b_hit_r && b_empty_r) begin
      idle_r[b_idx_r] <= b_idle_nxt;
    end
  end

  // Stage C control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
  end

  // Stage C payload.
  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      c_hit_r  <= b_hit_r;
      c_idx_r  <= b_idx_r;
      c_prod_r <= b_prod_sat;
      c_occ_r  <= b_occ_r;
      c_peak_r <= b_peak_r;
      c_idle_r <= b_empty_r ? b_idle_nxt : b_idle_old;
      c_stat_r <= b_stat_r;
    end
  end

  // Stage C: saturating weighted-sum accumulation.
  always_comb begin
    c_sum      = {1'b0, wsum_r[c_idx_r]} + {1'b0, c_prod_r};
    c_wsum_nxt = c_sum[SUM_W] ? SUM_MAX : c_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wsum_r[i] <= '0;
      end
    end else if (c_valid_r && c_hit_r) begin
      wsum_r[c_idx_r] <= c_wsum_nxt;
    end
  end

  // A transaction for a queue that does not exist reports all zeros.
  always_comb begin
    res_valid = c_valid_r;
    if (c_hit_r) begin
      res.occupancy    = c_occ_r;
      res.peak         = c_peak_r;
      res.weighted_sum = c_wsum_nxt;
      res.idle_time    = c_idle_r;
      res.status       = c_stat_r;
    end else begin
      res.occupancy    = '0;
      res.peak         = '0;
      res.weighted_sum = '0;
      res.idle_time    = '0;
      res.status       = ST_OK;
    end
  end

endmodule

>>> design/qom_out_fifo.sv
module qom_out_fifo (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_valid,
  input  qom_pkg::result_t                res,
  input  logic                            pop,
  output logic                            empty,
  output qom_pkg::result_t                head,
  output logic [qom_pkg::OUT_LVL_W-1:0]   level
);
  import qom_pkg::*;

  localparam int PTW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

  result_t               mem_r [OUT_DEPTH];
  logic [PTW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [OUT_LVL_W-1:0]  cnt_r, cnt_nxt;
  logic                  do_pop;

  assign empty  = (cnt_r == '0);
  assign level  = cnt_r;
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  // The back part never issues past the free space, so a write always fits.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (res_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (res_valid && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !res_valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

endmodule

>>> design/queue_occupancy_monitor.sv
// Time-weighted occupancy monitor for up to NUM_QUEUES queues. Each input
// transaction is an enter or leave event with a tick timestamp; it returns one
// result with the queue's occupancy, peak, saturating weighted sum, idle time and
// a status code. The block takes one event per clock cycle while the result queue
// has room for all results in flight, back-to-back events to one queue included;
// an event passes the stage B and C registers before its result is written into
// the result queue. The rate is set by the per-queue read-modify-write kept inside
// each back-end stage (count and peak, then idle time and the
// count-by-interval multiply, then the weighted-sum add). Two-entry input and
// four-entry result queues let the sides stall independently. Events for a queue
// number at or above NUM_QUEUES change nothing and return all zeros.
module queue_occupancy_monitor #(
  parameter int NUM_QUEUES  = 3,
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_op,
  input  logic [qom_pkg::SEL_W-1:0]    in_queue_sel,
  input  logic [qom_pkg::TS_W-1:0]     in_timestamp,
  output logic                         empty,
  input  logic                         pop,
  output logic [qom_pkg::OCC_W-1:0]    out_occupancy,
  output logic [qom_pkg::OCC_W-1:0]    out_peak,
  output logic [qom_pkg::SUM_W-1:0]    out_weighted_sum,
  output logic [qom_pkg::IDLE_W-1:0]   out_idle_time,
  output logic [1:0]                   out_status
);
  import qom_pkg::*;

  logic                  ev_valid;
  event_t                ev;
  logic                  ev_take;
  logic [OUT_LVL_W-1:0]  out_level;
  logic                  res_valid;
  result_t               res;
  result_t               head;

  // Front: accept and classify events.
  qom_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (push),
    .in_full      (full),
    .in_op        (in_op),
    .in_queue_sel (in_queue_sel),
    .in_timestamp (in_timestamp),
    .ev_valid     (ev_valid),
    .ev           (ev),
    .ev_take      (ev_take)
  );

  // Back: per-queue statistics pipeline.
  qom_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .ev_take   (ev_take),
    .out_level (out_level),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue.
  qom_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .pop       (pop),
    .empty     (empty),
    .head      (head),
    .level     (out_level)
  );

  assign out_occupancy    = head.occupancy;
  assign out_peak         = head.peak;
  assign out_weighted_sum = head.weighted_sum;
  assign out_idle_time    = head.idle_time;
  assign out_status       = head.status;

endmodule

>>> design/qom_checker.sv
module qom_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [qom_pkg::OCC_W-1:0]    out_occupancy,
  input logic [qom_pkg::OCC_W-1:0]    out_peak,
  input logic [qom_pkg::SUM_W-1:0]    out_weighted_sum,
  input logic [qom_pkg::IDLE_W-1:0]   out_idle_time,
  input logic [1:0]                   out_status
);
  import qom_pkg::*;

  // The result queue comes out of reset empty and the input queue not full.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting result that is not taken stays unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_occupancy) && $stable(out_peak) &&
                          $stable(out_weighted_sum) && $stable(out_idle_time) &&
                          $stable(out_status)))
    else $error("waiting result changed");

  // Occupancy never exceeds the recorded peak while COUNT_WIDTH is no wider than OCC_W.
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (COUNT_WIDTH <= OCC_W)) |-> (out_occupancy <= out_peak))
    else $error("occupancy above peak");

  // A remove from an empty queue leaves it empty.
  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == ST_EMPTY_REMOVE)) |-> (out_occupancy == '0))
    else $error("remove from empty reported nonzero occupancy");

endmodule

bind queue_occupancy_monitor qom_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_qom_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .full             (full),
  .empty            (empty),
  .pop              (pop),
  .out_occupancy    (out_occupancy),
  .out_peak         (out_peak),
  .out_weighted_sum (out_weighted_sum),
  .out_idle_time    (out_idle_time),
  .out_status       (out_status)
);
